/* hdl/dcc_pkg.sv */
package dcc_pkg;

  localparam int NumRegs = 10;
  localparam int UpcW = 4;

  // Item commands.
  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdExec  = 2'd2;

  // Result status codes.
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StHalted  = 3'd1;
  localparam logic [2:0] StStopped = 3'd2;
  localparam logic [2:0] StBadOp   = 3'd3;
  localparam logic [2:0] StBadPc   = 3'd4;

  // Instruction opcodes.
  localparam logic [5:0] OpHalt = 6'd0;
  localparam logic [5:0] OpLd   = 6'd1;
  localparam logic [5:0] OpSt   = 6'd2;
  localparam logic [5:0] OpAdd  = 6'd3;
  localparam logic [5:0] OpNeg  = 6'd4;
  localparam logic [5:0] OpLdm  = 6'd5;
  localparam logic [5:0] OpAddm = 6'd6;
  localparam logic [5:0] OpBr   = 6'd7;
  localparam logic [5:0] OpBrc  = 6'd8;
  localparam logic [5:0] OpTrap = 6'd9;

  // Trap selectors in the register digit.
  localparam logic [3:0] TrapGetc = 4'd0;
  localparam logic [3:0] TrapOut  = 4'd1;

  // Decimal digit extraction: x / 1000 = (x * 33555) >> 25 for x below 2^15 + 1,
  // and x / 100 = (x * 41) >> 12 for x below 1000.
  localparam logic [15:0] RecipK1000 = 16'd33555;
  localparam logic [15:0] RecipK100  = 16'd41;
  localparam logic [15:0] K1000      = 16'd1000;
  localparam logic [9:0]  K100       = 10'd100;

  // Datapath actions.
  localparam logic [3:0] ActNone    = 4'd0;
  localparam logic [3:0] ActAccept  = 4'd1;
  localparam logic [3:0] ActMemWr   = 4'd2;
  localparam logic [3:0] ActRdAddr  = 4'd3;
  localparam logic [3:0] ActRdCap   = 4'd4;
  localparam logic [3:0] ActFetch   = 4'd5;
  localparam logic [3:0] ActLatch   = 4'd6;
  localparam logic [3:0] ActDiv1000 = 4'd7;
  localparam logic [3:0] ActRem1000 = 4'd8;
  localparam logic [3:0] ActDiv100  = 4'd9;
  localparam logic [3:0] ActRem100  = 4'd10;
  localparam logic [3:0] ActExec    = 4'd11;
  localparam logic [3:0] ActMemAcc  = 4'd12;
  localparam logic [3:0] ActEmit    = 4'd13;

  // Jump conditions.
  localparam logic [2:0] CondNever   = 3'd0;
  localparam logic [2:0] CondAlways  = 3'd1;
  localparam logic [2:0] CondNoItem  = 3'd2;
  localparam logic [2:0] CondNoFetch = 3'd3;
  localparam logic [2:0] CondNoMemOp = 3'd4;
  localparam logic [2:0] CondOutBusy = 3'd5;

  // Microprogram step addresses.
  localparam logic [UpcW-1:0] UIdle    = 4'd0;
  localparam logic [UpcW-1:0] UDisp    = 4'd1;
  localparam logic [UpcW-1:0] UWrite   = 4'd2;
  localparam logic [UpcW-1:0] URead    = 4'd3;
  localparam logic [UpcW-1:0] UReadCap = 4'd4;
  localparam logic [UpcW-1:0] UFetch   = 4'd5;
  localparam logic [UpcW-1:0] ULatch   = 4'd6;
  localparam logic [UpcW-1:0] UDiv1000 = 4'd7;
  localparam logic [UpcW-1:0] URem1000 = 4'd8;
  localparam logic [UpcW-1:0] UDiv100  = 4'd9;
  localparam logic [UpcW-1:0] URem100  = 4'd10;
  localparam logic [UpcW-1:0] UExec    = 4'd11;
  localparam logic [UpcW-1:0] UMemAcc  = 4'd12;
  localparam logic [UpcW-1:0] UDone    = 4'd13;

  typedef struct packed {
    logic [3:0]      act;
    logic [2:0]      cond;
    logic            dispatch;
    logic [UpcW-1:0] tgt;
    logic [UpcW-1:0] nxt;
  } uword_t;

  // Control store: by command on dispatch, else tgt if cond holds, else nxt.
  function automatic uword_t ucode(logic [UpcW-1:0] upc);
    uword_t w;
    case (upc)
      UIdle:    w = '{ActAccept,  CondNoItem,  1'b0, UIdle, UDisp};
      UDisp:    w = '{ActNone,    CondNever,   1'b1, UIdle, UIdle};
      UWrite:   w = '{ActMemWr,   CondNever,   1'b0, UIdle, UDone};
      URead:    w = '{ActRdAddr,  CondNever,   1'b0, UIdle, UReadCap};
      UReadCap: w = '{ActRdCap,   CondNever,   1'b0, UIdle, UDone};
      UFetch:   w = '{ActFetch,   CondNoFetch, 1'b0, UDone, ULatch};
      ULatch:   w = '{ActLatch,   CondNever,   1'b0, UIdle, UDiv1000};
      UDiv1000: w = '{ActDiv1000, CondNever,   1'b0, UIdle, URem1000};
      URem1000: w = '{ActRem1000, CondNever,   1'b0, UIdle, UDiv100};
      UDiv100:  w = '{ActDiv100,  CondNever,   1'b0, UIdle, URem100};
      URem100:  w = '{ActRem100,  CondNever,   1'b0, UIdle, UExec};
      UExec:    w = '{ActExec,    CondNoMemOp, 1'b0, UDone, UMemAcc};
      UMemAcc:  w = '{ActMemAcc,  CondNever,   1'b0, UIdle, UDone};
      UDone:    w = '{ActEmit,    CondOutBusy, 1'b0, UDone, UIdle};
      default:  w = '{ActNone,    CondNever,   1'b0, UIdle, UIdle};
    endcase
    return w;
  endfunction

endpackage

/* hdl/dcc_ram.sv */
module dcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/decimal_computer_core.sv */
// Decimal teaching computer core. Each input item carries a command in tuser:
// write a memory word, read a memory word, or execute one instruction; every
// item gives exactly one result item. A small microprogram steps a plain
// datapath around one memory: each item is accepted, dispatched and ends in a
// result step; a write adds a memory write step, a read address and capture
// steps, and an execute fetches the word, decodes it into decimal digits in four
// steps of two reciprocal multiplications and their remainders, executes it and,
// for load and add, makes a second memory access; while stopped or with the
// program counter out of range it skips from fetch to result. The next item is
// taken while a result still waits in the output register. Memory words are
// undefined until written, and there is no clearing pass after reset; registers
// are cleared, the program counter starts at zero and the machine starts in the
// running state. A program counter at or beyond MEM_WORDS stops the machine.
module decimal_computer_core #(
  parameter int MEM_WORDS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] mem_addr, [22:7] write_value, [30:23] in_char, [31] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] read_value, [18:16] status, [19] char_valid, [27:20] out_char,
  // [34:28] prog_counter, [35] is_running, [39:36] zero
  output logic [39:0] m_axis_tdata_o
);

  localparam int AddrW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [7:0] MemLim = 8'(MEM_WORDS);

  localparam int UpcW = dcc_pkg::UpcW;

  logic [UpcW-1:0] upc_q, upc_d;
  dcc_pkg::uword_t uw;
  logic            cond_hit;

  // Item fields.
  logic [1:0]  cmd_q;
  logic [6:0]  addr_q;
  logic [15:0] wval_q;
  logic [7:0]  ch_q;

  // Machine state.
  logic [15:0] regs_q [dcc_pkg::NumRegs];
  logic [6:0]  pc_q;
  logic        run_q;
  logic [15:0] instr_q;

  // Decode.
  logic [15:0] mag_q;
  logic [5:0]  opc_q;
  logic [9:0]  rem_q;
  logic [3:0]  rdig_q;
  logic [6:0]  mm_q;
  logic [31:0] prod_k1000;
  logic [15:0] prod_k100;

  // Result under construction and output register.
  logic [15:0] rv_q;
  logic [2:0]  status_q;
  logic        cv_q;
  logic [7:0]  oc_q;
  logic        out_valid_q;
  logic [35:0] out_q;

  // Memory port.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  logic        addr_ok, pc_ok, mm_ok, out_busy;
  logic [15:0] reg_sel, sgn_mm, mem_val;
  logic        brc_take;

  assign addr_ok  = {1'b0, addr_q} < MemLim;
  assign pc_ok    = {1'b0, pc_q} < MemLim;
  assign mm_ok    = {1'b0, mm_q} < MemLim;
  assign out_busy = out_valid_q && !m_axis_tready_i;

  assign reg_sel  = regs_q[rdig_q];
  assign sgn_mm   = instr_q[15] ? (16'd0 - {9'd0, mm_q}) : {9'd0, mm_q};
  assign mem_val  = mm_ok ? ram_rdata : 16'd0;
  // The word sign is never zero for a branch word, so a zero register never branches.
  assign brc_take = (reg_sel != 16'd0) && (reg_sel[15] == instr_q[15]);

  assign prod_k1000 = {16'd0, mag_q} * {16'd0, dcc_pkg::RecipK1000};
  assign prod_k100  = {6'd0, rem_q} * dcc_pkg::RecipK100;

  assign uw = dcc_pkg::ucode(upc_q);

  always_comb begin
    case (uw.cond)
      dcc_pkg::CondNever:   cond_hit = 1'b0;
      dcc_pkg::CondAlways:  cond_hit = 1'b1;
      dcc_pkg::CondNoItem:  cond_hit = !s_axis_tvalid_i;
      dcc_pkg::CondNoFetch: cond_hit = !run_q || !pc_ok;
      dcc_pkg::CondNoMemOp: cond_hit = !(opc_q inside {dcc_pkg::OpLd, dcc_pkg::OpAdd});
      dcc_pkg::CondOutBusy: cond_hit = out_busy;
      default:              cond_hit = 1'b0;
    endcase
    if (uw.dispatch) begin
      case (cmd_q)
        dcc_pkg::CmdWrite: upc_d = dcc_pkg::UWrite;
        dcc_pkg::CmdRead:  upc_d = dcc_pkg::URead;
        dcc_pkg::CmdExec:  upc_d = dcc_pkg::UFetch;
        default:           upc_d = dcc_pkg::UDone;
      endcase
    end else begin
      upc_d = cond_hit ? uw.tgt : uw.nxt;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_q[AddrW-1:0];
    ram_wdata = wval_q;
    ram_raddr = addr_q[AddrW-1:0];
    case (uw.act)
      dcc_pkg::ActMemWr: begin
        ram_we = addr_ok;
      end
      dcc_pkg::ActRdAddr: begin
        ram_re = addr_ok;
      end
      dcc_pkg::ActFetch: begin
        ram_re    = run_q && pc_ok;
        ram_raddr = pc_q[AddrW-1:0];
      end
      dcc_pkg::ActExec: begin
        ram_waddr = mm_q[AddrW-1:0];
        ram_wdata = reg_sel;
        ram_raddr = mm_q[AddrW-1:0];
        ram_we    = (opc_q == dcc_pkg::OpSt) && mm_ok;
        ram_re    = (opc_q inside {dcc_pkg::OpLd, dcc_pkg::OpAdd}) && mm_ok;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dcc_ram #(
    .WIDTH(16),
    .DEPTH(MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and machine state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= dcc_pkg::UIdle;
      out_valid_q <= 1'b0;
      pc_q        <= 7'd0;
      run_q       <= 1'b1;
      instr_q     <= 16'd0;
      for (int i = 0; i < dcc_pkg::NumRegs; i++) begin
        regs_q[i] <= 16'd0;
      end
    end else begin
      upc_q <= upc_d;
      if ((uw.act == dcc_pkg::ActEmit) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uw.act)
        dcc_pkg::ActFetch: begin
          if (run_q && !pc_ok) begin
            run_q <= 1'b0;
          end
        end
        dcc_pkg::ActLatch: begin
          instr_q <= ram_rdata;
          pc_q    <= pc_q + 7'd1;
        end
        dcc_pkg::ActExec: begin
          case (opc_q)
            dcc_pkg::OpHalt: run_q <= 1'b0;
            dcc_pkg::OpNeg:  regs_q[rdig_q] <= 16'd0 - reg_sel;
            dcc_pkg::OpLdm:  regs_q[rdig_q] <= sgn_mm;
            dcc_pkg::OpAddm: regs_q[rdig_q] <= reg_sel + sgn_mm;
            dcc_pkg::OpBr:   pc_q <= mm_q;
            dcc_pkg::OpBrc: begin
              if (brc_take) begin
                pc_q <= mm_q;
              end
            end
            dcc_pkg::OpTrap: begin
              if (rdig_q == dcc_pkg::TrapGetc) begin
                regs_q[0] <= {8'd0, ch_q};
              end
            end
            default: ;
          endcase
        end
        dcc_pkg::ActMemAcc: begin
          if (opc_q == dcc_pkg::OpLd) begin
            regs_q[rdig_q] <= mem_val;
          end else begin
            regs_q[rdig_q] <= reg_sel + mem_val;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: item fields, decode digits and the result.
  always_ff @(posedge clk_i) begin
    case (uw.act)
      dcc_pkg::ActAccept: begin
        if (s_axis_tvalid_i) begin
          cmd_q    <= s_axis_tuser_i;
          addr_q   <= s_axis_tdata_i[6:0];
          wval_q   <= s_axis_tdata_i[22:7];
          ch_q     <= s_axis_tdata_i[30:23];
          rv_q     <= 16'd0;
          status_q <= dcc_pkg::StOk;
          cv_q     <= 1'b0;
          oc_q     <= 8'd0;
        end
      end
      dcc_pkg::ActRdCap: begin
        rv_q <= addr_ok ? ram_rdata : 16'd0;
      end
      dcc_pkg::ActFetch: begin
        if (!run_q) begin
          status_q <= dcc_pkg::StStopped;
        end else if (!pc_ok) begin
          status_q <= dcc_pkg::StBadPc;
        end
      end
      dcc_pkg::ActLatch: begin
        mag_q <= ram_rdata[15] ? (16'd0 - ram_rdata) : ram_rdata;
      end
      dcc_pkg::ActDiv1000: begin
        opc_q <= prod_k1000[30:25];
      end
      dcc_pkg::ActRem1000: begin
        rem_q <= 10'(mag_q - {10'd0, opc_q} * dcc_pkg::K1000);
      end
      dcc_pkg::ActDiv100: begin
        rdig_q <= prod_k100[15:12];
      end
      dcc_pkg::ActRem100: begin
        mm_q <= 7'(rem_q - {6'd0, rdig_q} * dcc_pkg::K100);
      end
      dcc_pkg::ActExec: begin
        if (opc_q == dcc_pkg::OpHalt) begin
          status_q <= dcc_pkg::StHalted;
        end else if (opc_q > dcc_pkg::OpTrap) begin
          status_q <= dcc_pkg::StBadOp;
        end else if ((opc_q == dcc_pkg::OpTrap) && (rdig_q == dcc_pkg::TrapOut)) begin
          cv_q <= 1'b1;
          oc_q <= regs_q[0][7:0];
        end
      end
      dcc_pkg::ActEmit: begin
        if (!out_busy) begin
          out_q <= {run_q, pc_q, oc_q, cv_q, status_q, rv_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (upc_q == dcc_pkg::UIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q};

endmodule

/* dv/decimal_computer_core_tb.sv */
`timescale 1ns / 1ps

module decimal_computer_core_tb;

  localparam int MemWords = 100;
  localparam int ItemTarget = 1630;
  localparam logic [1:0] CmdNone = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [6:0]  addr;
    logic [15:0] wval;
    logic [7:0]  ch;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic        is_running;
    logic [6:0]  prog_counter;
    logic [7:0]  out_char;
    logic        char_valid;
    logic [2:0]  status;
    logic [15:0] read_value;
  } result_t;

  class machine_scoreboard;
    logic [15:0] words [MemWords];
    logic [15:0] regfile [dcc_pkg::NumRegs];
    logic [6:0]  pc;
    logic        running;
    result_t     expected_results [$];
    int          fail_count;

    function new();
      foreach (regfile[i]) regfile[i] = 16'd0;
      foreach (words[i]) words[i] = 16'd0;
      pc = 7'd0;
      running = 1'b1;
      fail_count = 0;
    endfunction

    function int polarity(int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Splits an instruction word into its decimal digits by magnitude.
    function void decode(input logic [15:0] w, output int op, output int rn,
                         output int mm, output int sgn);
      int v;
      int mag;
      v = $signed(w);
      mag = (v < 0) ? -v : v;
      sgn = polarity(v);
      op = mag / 1000;
      rn = (mag / 100) % 10;
      mm = mag % 100;
    endfunction

    function void accept_item(cmd_item_t it);
      result_t want;
      int op, rn, mm, sgn;
      want = '0;
      case (it.cmd)
        dcc_pkg::CmdWrite: if (it.addr < MemWords) words[it.addr] = it.wval;
        dcc_pkg::CmdRead: if (it.addr < MemWords) want.read_value = words[it.addr];
        dcc_pkg::CmdExec: begin
          if (!running) begin
            want.status = dcc_pkg::StStopped;
          end else if (pc >= MemWords) begin
            running = 1'b0;
            want.status = dcc_pkg::StBadPc;
          end else begin
            decode(words[pc], op, rn, mm, sgn);
            pc = pc + 7'd1;
            want.status = dcc_pkg::StOk;
            case (op)
              dcc_pkg::OpHalt: begin
                running = 1'b0;
                want.status = dcc_pkg::StHalted;
              end
              dcc_pkg::OpLd: regfile[rn] = (mm < MemWords) ? words[mm] : 16'd0;
              dcc_pkg::OpSt: if (mm < MemWords) words[mm] = regfile[rn];
              dcc_pkg::OpAdd:
                regfile[rn] = regfile[rn] + ((mm < MemWords) ? words[mm] : 16'd0);
              dcc_pkg::OpNeg: regfile[rn] = 16'd0 - regfile[rn];
              dcc_pkg::OpLdm: regfile[rn] = 16'(sgn * mm);
              dcc_pkg::OpAddm: regfile[rn] = regfile[rn] + 16'(sgn * mm);
              dcc_pkg::OpBr: pc = 7'(mm);
              dcc_pkg::OpBrc: if (polarity($signed(regfile[rn])) == sgn) pc = 7'(mm);
              dcc_pkg::OpTrap: begin
                if (rn == dcc_pkg::TrapGetc) begin
                  regfile[0] = {8'd0, it.ch};
                end else if (rn == dcc_pkg::TrapOut) begin
                  want.char_valid = 1'b1;
                  want.out_char = regfile[0][7:0];
                end
              end
              default: want.status = dcc_pkg::StBadOp;
            endcase
          end
        end
        default: ;
      endcase
      want.prog_counter = pc;
      want.is_running = running;
      expected_results.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result item with nothing expected: %h", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.pad !== want.pad || got.is_running !== want.is_running ||
          got.prog_counter !== want.prog_counter || got.out_char !== want.out_char ||
          got.char_valid !== want.char_valid || got.status !== want.status ||
          got.read_value !== want.read_value) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"mismatch: expected rd=%h st=%0d cv=%b ch=%h pc=%0d run=%b pad=%h, ",
                    "got rd=%h st=%0d cv=%b ch=%h pc=%0d run=%b pad=%h"},
                   want.read_value, want.status, want.char_valid, want.out_char,
                   want.prog_counter, want.is_running, want.pad,
                   got.read_value, got.status, got.char_valid, got.out_char,
                   got.prog_counter, got.is_running, got.pad);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;

  machine_scoreboard sb = new();
  bit tx_burst = 1'b0;
  int n_sent = 0;

  decimal_computer_core #(
    .MEM_WORDS(MemWords)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_instr();
    int op, rn, mag;
    bit neg;
    op = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 32) : $urandom_range(1, 9);
    if (op == dcc_pkg::OpTrap)
      rn = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : $urandom_range(0, 1);
    else
      rn = $urandom_range(0, 9);
    mag = op * 1000 + rn * 100 + $urandom_range(0, 99);
    if (mag > 32768) mag = $urandom_range(10000, 32767);
    neg = $urandom_range(0, 1);
    if (mag == 32768) neg = 1'b1;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [6:0] rand_addr();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(100, 127));
    return 7'($urandom_range(0, 99));
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic [6:0] addr,
                           input logic [15:0] wval);
    cmd_item_t it;
    int gap;
    it.cmd = cmd;
    it.addr = addr;
    it.wval = wval;
    it.ch = 8'($urandom);
    gap = tx_burst ? 0 : idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, it.ch, it.wval, it.addr};
    s_tuser <= it.cmd;
    do @(posedge clk); while (!s_tready);
    sb.accept_item(it);
    n_sent++;
  endtask

  task automatic push_exec();
    push_item(dcc_pkg::CmdExec, 7'($urandom), 16'($urandom));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    int n_rx;
    bit long_done;
    bit rx_burst;
    stall_left = 0;
    n_rx = 0;
    long_done = 1'b0;
    rx_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        n_rx++;
        if (n_rx % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
      // One long hold-off so the block backs up and stalls its input.
      if (!long_done && n_rx >= 400) begin
        long_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_burst && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  initial begin : stimulus
    int prog [19];
    int op, rn, mm, sgn, pick, k;
    logic [15:0] val;
    // Directed program: immediates of both signs, store and load back, add,
    // negate, getc, out, an empty trap, conditional branches on a zero, a
    // negative and a mismatched register, two bad opcodes and a jump to 99.
    prog = '{5199, -5250, 6150, -6120, 4100, 2198, 1398, 3398, 9000, 9100, 9500,
             8430, -8430, -8215, 7000, 8317, 12345, -32768, 7099};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every word is written before anything can read it.
    for (int i = 0; i < MemWords; i++) begin
      if (i < 19) val = 16'(prog[i]);
      else if (i == 99) val = 16'(7020);
      else if ($urandom_range(0, 9) < 7) val = rand_instr();
      else val = 16'($urandom);
      push_item(dcc_pkg::CmdWrite, 7'(i), val);
    end

    push_item(dcc_pkg::CmdRead, 7'd99, 16'($urandom));
    push_item(dcc_pkg::CmdWrite, 7'd127, 16'hffff);
    push_item(dcc_pkg::CmdRead, 7'd127, 16'($urandom));
    push_item(CmdNone, 7'($urandom), 16'($urandom));
    push_item(dcc_pkg::CmdWrite, 7'd97, 16'h7fff);
    push_item(dcc_pkg::CmdWrite, 7'd96, 16'h8000);
    push_item(dcc_pkg::CmdRead, 7'd97, 16'($urandom));
    push_item(dcc_pkg::CmdRead, 7'd96, 16'($urandom));
    repeat (19) push_exec();

    k = 0;
    while (n_sent < ItemTarget) begin
      if (k % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (k == 700) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Keep the machine alive: no halt word at the fetch address, and a
        // plain jump at the last word so the counter never runs off the end.
        sb.decode(sb.words[sb.pc], op, rn, mm, sgn);
        if (sb.pc == 7'd99 && op != dcc_pkg::OpBr)
          push_item(dcc_pkg::CmdWrite, 7'd99, 16'(7000 + $urandom_range(0, 99)));
        else if (op == dcc_pkg::OpHalt)
          push_item(dcc_pkg::CmdWrite, sb.pc, rand_instr());
        push_exec();
      end else if (pick < 80) begin
        push_item(dcc_pkg::CmdWrite, rand_addr(),
                  $urandom_range(0, 1) ? rand_instr() : 16'($urandom));
      end else if (pick < 95) begin
        push_item(dcc_pkg::CmdRead, rand_addr(), 16'($urandom));
      end else begin
        push_item(CmdNone, 7'($urandom), 16'($urandom));
      end
      k++;
    end

    // The machine stops for good here, by a halt word of zero or by running
    // off the end of memory; further executes report it as not running.
    tx_burst = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      push_item(dcc_pkg::CmdWrite, sb.pc, 16'd0);
      push_exec();
    end else begin
      push_item(dcc_pkg::CmdWrite, 7'd99, 16'(9100));
      if (sb.pc != 7'd99) begin
        push_item(dcc_pkg::CmdWrite, sb.pc, 16'(7099));
        push_exec();
      end
      push_exec();
      push_exec();
    end
    push_exec();
    push_item(dcc_pkg::CmdRead, 7'd99, 16'($urandom));
    push_exec();

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.fail_count += sb.expected_results.size();
      $display("%0d expected result items never arrived", sb.expected_results.size());
    end
    if (sb.fail_count == 0) begin
      $display("decimal_computer_core verification clean");
    end else begin
      $display("decimal_computer_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("decimal_computer_core verification failed");
    $finish;
  end

endmodule
